@@ src/akf_pkg.sv @@
// Shared types and constants of the angle Kalman filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package akf_pkg;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 47;
  localparam int unsigned FieldBits   = 48;

  localparam logic [CfgIdxBits-1:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_ANGLE_NOISE   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_DRIFT_NOISE   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_MEASURE_GAIN  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_MEASURE_NOISE = 3'd4;

  localparam logic [32:0] RST_TIME_STEP     = 33'd21474836;
  localparam logic [32:0] RST_ANGLE_NOISE   = 33'd4294967;
  localparam logic [32:0] RST_DRIFT_NOISE   = 33'd12884902;
  localparam logic [7:0]  RST_MEASURE_GAIN  = 8'd1;
  localparam logic [46:0] RST_MEASURE_NOISE = 47'd2147483648;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  // One entry per step of the update sequence, in execution order.
  typedef enum logic [4:0] {
    ST_D0A, ST_D0B, ST_D1, ST_P0, ST_M1, ST_P1, ST_P2, ST_P3,
    ST_PCT0, ST_PCT1, ST_E, ST_K0, ST_K1, ST_T1,
    ST_C0, ST_C1, ST_C2, ST_C3,
    ST_G, ST_ANG, ST_ERR, ST_BIAS, ST_SPD, ST_FIN
  } step_e;

  typedef enum logic [1:0] {
    K_ALU,
    K_MUL,
    K_DIV
  } kind_e;

  typedef enum logic [1:0] {
    P_NONE,
    P_ADD,
    P_SUB
  } post_e;

  typedef enum logic [3:0] {
    D_D0, D_D1, D_P0, D_P1, D_P2, D_P3, D_PCT0, D_PCT1,
    D_E, D_K0, D_K1, D_T1, D_ERR, D_ANG, D_BIAS, D_SPD
  } dst_e;

  // Handshake between the sequencer and an arithmetic unit.
  typedef struct packed {
    logic start;
    logic frac;
  } unit_ctl_t;

endpackage

@@ src/akf_mul.sv @@
// Bit-serial signed multiplier: shift-add one multiplier bit per cycle,
// then, in fraction mode, round and shift, then saturate. Uses akf_pkg.
`timescale 1ns / 1ps

module akf_mul #(
  parameter int unsigned W = 48,
  parameter int unsigned F = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  akf_pkg::unit_ctl_t  ctl_i,
  input  logic [W-1:0]        a_i,
  input  logic [W-1:0]        b_i,
  output logic                done_o,
  output logic [W-1:0]        y_o
);
  import akf_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned PW = 2 * W + F;
  localparam logic [W:0]   MAXE = {2'b00, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};

  logic [W-1:0]  ma_q, mb_q, hi_q, lo_q, y_q;
  logic          neg_q, frac_q, run_q, fin_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    sum;
  logic [PW-1:0] pe;
  logic          hi_nz;
  logic [W:0]    low;
  logic [W-1:0]  sat_y;

  assign sum = {1'b0, hi_q} + (mb_q[0] ? {1'b0, ma_q} : '0);

  always_comb begin
    pe = PW'({hi_q, lo_q});
    if (frac_q) begin
      hi_nz = |pe[PW-1:W+F];
      low   = {1'b0, pe[W+F-1:F]} + (W + 1)'(pe[F-1]);
    end else begin
      hi_nz = |pe[PW-1:W];
      low   = {1'b0, pe[W-1:0]};
    end
    if (!neg_q) begin
      sat_y = (hi_nz || low > MAXE) ? MAXW : low[W-1:0];
    end else begin
      sat_y = (hi_nz || low > MAXE + 1'b1) ? MINW : W'(~low[W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      ma_q   <= a_i[W-1] ? W'(~a_i + 1'b1) : a_i;
      mb_q   <= b_i[W-1] ? W'(~b_i + 1'b1) : b_i;
      neg_q  <= a_i[W-1] ^ b_i[W-1];
      frac_q <= ctl_i.frac;
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (run_q) begin
      hi_q <= sum[W:1];
      lo_q <= {sum[0], lo_q[W-1:1]};
      mb_q <= {1'b0, mb_q[W-1:1]};
    end
    if (fin_q) begin
      y_q <= sat_y;
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

@@ src/akf_div.sv @@
// Restoring divider, one quotient bit per cycle: (|num| << F) / den,
// truncated toward zero and saturated. Uses akf_pkg.
`timescale 1ns / 1ps

module akf_div #(
  parameter int unsigned W = 48,
  parameter int unsigned F = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  akf_pkg::unit_ctl_t  ctl_i,
  input  logic [W-1:0]        num_i,
  input  logic [W-1:0]        den_i,
  output logic                done_o,
  output logic [W-1:0]        y_o
);
  import akf_pkg::*;

  localparam int unsigned QW = W + F;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [W:0]   MAXE = {2'b00, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};

  logic [QW-1:0] dsr_q, quo_q;
  logic [W-1:0]  rem_q, den_q, y_q;
  logic          neg_q, run_q, fin_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    trial, diff;
  logic          ge;
  logic          hi_nz;
  logic [W:0]    low;
  logic [W-1:0]  sat_y;

  assign trial = {rem_q, dsr_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    hi_nz = |quo_q[QW-1:W];
    low   = {1'b0, quo_q[W-1:0]};
    if (!neg_q) begin
      sat_y = (hi_nz || low > MAXE) ? MAXW : low[W-1:0];
    end else begin
      sat_y = (hi_nz || low > MAXE + 1'b1) ? MINW : W'(~low[W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CW'(QW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dsr_q <= {(num_i[W-1] ? W'(~num_i + 1'b1) : num_i), {F{1'b0}}};
      den_q <= den_i;
      neg_q <= num_i[W-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
      dsr_q <= {dsr_q[QW-2:0], 1'b0};
    end
    if (fin_q) begin
      y_q <= sat_y;
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

@@ src/angle_kalman_filter.sv @@
// Two-state (angle, gyro bias) Kalman filter; top level with the step sequencer.
// Depends on akf_pkg, akf_mul and akf_div.
//
// One sample is processed at a time. The update runs as 24 steps on a shared
// bit-serial multiplier (14 products) and a restoring divider (two gains, each
// set to zero without the divider when the innovation variance is not positive);
// the saturating add and subtract steps use neither unit. The result sits in an
// output register, so the next sample is accepted while it waits. Configuration
// is to be written only while the block is idle; the block does not enforce it.
// Samples and results are signed fixed point with FRAC_BITS fraction bits; the
// time step and noise values are unsigned with FRAC_BITS fraction bits, and the
// measure gain is a signed integer. All values saturate.
`timescale 1ns / 1ps

module angle_kalman_filter #(
  parameter int unsigned WORD_BITS = 48,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [akf_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [akf_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [akf_pkg::FieldBits-1:0] prior_angle_i,
  input  logic signed [akf_pkg::FieldBits-1:0] measured_angle_i,
  input  logic signed [akf_pkg::FieldBits-1:0] gyro_rate_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [akf_pkg::FieldBits-1:0] filtered_angle_o,
  output logic signed [akf_pkg::FieldBits-1:0] corrected_rate_o
);
  import akf_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned XW = (W > CfgDataBits) ? W : CfgDataBits;
  localparam int unsigned IW = (W > FieldBits) ? W : FieldBits;
  localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};
  localparam logic [FieldBits-1:0] MAXF = {1'b0, {(FieldBits - 1){1'b1}}};
  localparam logic [FieldBits-1:0] MINF = {1'b1, {(FieldBits - 1){1'b0}}};

  function automatic logic [W-1:0] cfg_sat(input logic [CfgDataBits-1:0] v);
    logic [XW-1:0] ve;
    ve = XW'(v);
    return (ve > XW'(MAXW)) ? MAXW : ve[W-1:0];
  endfunction

  function automatic logic [W-1:0] in_sat(input logic [FieldBits-1:0] v);
    logic signed [IW-1:0] ve;
    ve = IW'(signed'(v));
    if (ve > IW'(signed'(MAXW))) return MAXW;
    if (ve < IW'(signed'(MINW))) return MINW;
    return ve[W-1:0];
  endfunction

  function automatic logic [FieldBits-1:0] out_sat(input logic [W-1:0] v);
    logic signed [IW-1:0] ve;
    ve = IW'(signed'(v));
    if (ve > IW'(signed'(MAXF))) return MAXF;
    if (ve < IW'(signed'(MINF))) return MINF;
    return ve[FieldBits-1:0];
  endfunction

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? MINW : MAXW;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? MINW : MAXW;
    return s[W-1:0];
  endfunction

  // configuration
  logic [32:0] time_step_q, angle_noise_q, drift_noise_q;
  logic [7:0]  measure_gain_q;
  logic [46:0] measure_noise_q;
  logic        cfg_we;

  // filter state and working registers
  state_e       state_q, state_d;
  step_e        step_q, step_d;
  logic         busy_q, busy_d;
  logic [W-1:0] p0_q, p1_q, p2_q, p3_q, bias_q;
  logic [W-1:0] p0_d, p1_d, p2_d, p3_d, bias_d;
  logic [W-1:0] d0_q, d1_q, pct0_q, pct1_q, e_q, k0_q, k1_q, t1_q;
  logic [W-1:0] err_q, ang_q, spd_q, prior_q, meas_q, gyro_q;
  logic         out_valid_q;
  logic [FieldBits-1:0] filtered_angle_q, corrected_rate_q;

  logic [W-1:0] dt_w, qa_w, qg_w, r_w, c_w;
  kind_e        kind;
  post_e        post;
  dst_e         dst;
  logic         frac;
  logic [W-1:0] op_a, op_b, acc_x, src, wval;
  logic         wr_en, in_acc, slot_free, e_pos;
  unit_ctl_t    mul_ctl, div_ctl;
  logic         mul_done, div_done;
  logic [W-1:0] mul_y, div_y;

  assign dt_w  = cfg_sat(CfgDataBits'(time_step_q));
  assign qa_w  = cfg_sat(CfgDataBits'(angle_noise_q));
  assign qg_w  = cfg_sat(CfgDataBits'(drift_noise_q));
  assign r_w   = cfg_sat(measure_noise_q);
  assign c_w   = W'(signed'(measure_gain_q));
  assign e_pos = !e_q[W-1] && (e_q != '0);

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  // step decode: operands of the unit, the accumulate operand and target
  always_comb begin
    kind  = K_ALU;
    post  = P_NONE;
    dst   = D_D0;
    frac  = 1'b1;
    op_a  = '0;
    op_b  = '0;
    acc_x = '0;
    unique case (step_q)
      ST_D0A:  begin post = P_SUB; acc_x = qa_w; op_b = p1_q; dst = D_D0; end
      ST_D0B:  begin post = P_SUB; acc_x = d0_q; op_b = p2_q; dst = D_D0; end
      ST_D1:   begin post = P_SUB; acc_x = '0; op_b = p3_q; dst = D_D1; end
      ST_P0:   begin
        kind = K_MUL; op_a = d0_q; op_b = dt_w; post = P_ADD; acc_x = p0_q; dst = D_P0;
      end
      ST_M1:   begin kind = K_MUL; op_a = d1_q; op_b = dt_w; dst = D_D1; end
      ST_P1:   begin post = P_ADD; acc_x = p1_q; op_b = d1_q; dst = D_P1; end
      ST_P2:   begin post = P_ADD; acc_x = p2_q; op_b = d1_q; dst = D_P2; end
      ST_P3:   begin
        kind = K_MUL; op_a = qg_w; op_b = dt_w; post = P_ADD; acc_x = p3_q; dst = D_P3;
      end
      ST_PCT0: begin kind = K_MUL; frac = 1'b0; op_a = c_w; op_b = p0_q; dst = D_PCT0; end
      ST_PCT1: begin kind = K_MUL; frac = 1'b0; op_a = c_w; op_b = p2_q; dst = D_PCT1; end
      ST_E:    begin
        kind = K_MUL; frac = 1'b0; op_a = c_w; op_b = pct0_q; post = P_ADD;
        acc_x = r_w; dst = D_E;
      end
      ST_K0:   begin
        kind = e_pos ? K_DIV : K_ALU; op_a = pct0_q; op_b = e_pos ? e_q : '0; dst = D_K0;
      end
      ST_K1:   begin
        kind = e_pos ? K_DIV : K_ALU; op_a = pct1_q; op_b = e_pos ? e_q : '0; dst = D_K1;
      end
      ST_T1:   begin kind = K_MUL; frac = 1'b0; op_a = c_w; op_b = p1_q; dst = D_T1; end
      ST_C0:   begin
        kind = K_MUL; op_a = k0_q; op_b = pct0_q; post = P_SUB; acc_x = p0_q; dst = D_P0;
      end
      ST_C1:   begin
        kind = K_MUL; op_a = k0_q; op_b = t1_q; post = P_SUB; acc_x = p1_q; dst = D_P1;
      end
      ST_C2:   begin
        kind = K_MUL; op_a = k1_q; op_b = pct0_q; post = P_SUB; acc_x = p2_q; dst = D_P2;
      end
      ST_C3:   begin
        kind = K_MUL; op_a = k1_q; op_b = t1_q; post = P_SUB; acc_x = p3_q; dst = D_P3;
      end
      ST_G:    begin post = P_SUB; acc_x = gyro_q; op_b = bias_q; dst = D_ERR; end
      ST_ANG:  begin
        kind = K_MUL; op_a = err_q; op_b = dt_w; post = P_ADD; acc_x = prior_q; dst = D_ANG;
      end
      ST_ERR:  begin post = P_SUB; acc_x = meas_q; op_b = ang_q; dst = D_ERR; end
      ST_BIAS: begin
        kind = K_MUL; op_a = k1_q; op_b = err_q; post = P_ADD; acc_x = bias_q; dst = D_BIAS;
      end
      ST_SPD:  begin post = P_SUB; acc_x = gyro_q; op_b = bias_q; dst = D_SPD; end
      ST_FIN:  begin
        kind = K_MUL; op_a = k0_q; op_b = err_q; post = P_ADD; acc_x = ang_q; dst = D_ANG;
      end
      default: begin kind = K_ALU; end
    endcase
  end

  always_comb begin
    unique case (kind)
      K_MUL:   src = mul_y;
      K_DIV:   src = div_y;
      default: src = op_b;
    endcase
    unique case (post)
      P_ADD:   wval = sat_add(acc_x, src);
      P_SUB:   wval = sat_sub(acc_x, src);
      default: wval = src;
    endcase
  end

  assign mul_ctl.start = (state_q == S_RUN) && (kind == K_MUL) && !busy_q;
  assign mul_ctl.frac  = frac;
  assign div_ctl.start = (state_q == S_RUN) && (kind == K_DIV) && !busy_q;
  assign div_ctl.frac  = 1'b1;

  assign wr_en = (state_q == S_RUN) &&
                 ((kind == K_ALU) || (kind == K_MUL && mul_done) ||
                  (kind == K_DIV && div_done));

  akf_mul #(.W(W), .F(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mul_done),
    .y_o    (mul_y)
  );

  akf_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (op_a),
    .den_i  (op_b),
    .done_o (div_done),
    .y_o    (div_y)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    busy_d  = busy_q;
    p0_d    = p0_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    p3_d    = p3_q;
    bias_d  = bias_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RUN;
          step_d  = ST_D0A;
          busy_d  = 1'b0;
        end
      end
      S_RUN: begin
        if (mul_ctl.start || div_ctl.start) begin
          busy_d = 1'b1;
        end
        if (wr_en) begin
          busy_d = 1'b0;
          if (step_q == ST_FIN) begin
            state_d = S_DONE;
          end else begin
            step_d = step_e'(step_q + 1'b1);
          end
          unique case (dst)
            D_P0:    p0_d   = wval;
            D_P1:    p1_d   = wval;
            D_P2:    p2_d   = wval;
            D_P3:    p3_d   = wval;
            D_BIAS:  bias_d = wval;
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      step_q          <= ST_D0A;
      busy_q          <= 1'b0;
      p0_q            <= '0;
      p1_q            <= '0;
      p2_q            <= '0;
      p3_q            <= '0;
      bias_q          <= '0;
      out_valid_q     <= 1'b0;
      time_step_q     <= RST_TIME_STEP;
      angle_noise_q   <= RST_ANGLE_NOISE;
      drift_noise_q   <= RST_DRIFT_NOISE;
      measure_gain_q  <= RST_MEASURE_GAIN;
      measure_noise_q <= RST_MEASURE_NOISE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      busy_q  <= busy_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      p3_q    <= p3_d;
      bias_q  <= bias_d;
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index_i)
          CFG_TIME_STEP:     time_step_q     <= cfg_data_i[32:0];
          CFG_ANGLE_NOISE:   angle_noise_q   <= cfg_data_i[32:0];
          CFG_DRIFT_NOISE:   drift_noise_q   <= cfg_data_i[32:0];
          CFG_MEASURE_GAIN:  measure_gain_q  <= cfg_data_i[7:0];
          CFG_MEASURE_NOISE: measure_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prior_q <= in_sat(prior_angle_i);
      meas_q  <= in_sat(measured_angle_i);
      gyro_q  <= in_sat(gyro_rate_i);
    end
    if (wr_en) begin
      unique case (dst)
        D_D0:    d0_q   <= wval;
        D_D1:    d1_q   <= wval;
        D_PCT0:  pct0_q <= wval;
        D_PCT1:  pct1_q <= wval;
        D_E:     e_q    <= wval;
        D_K0:    k0_q   <= wval;
        D_K1:    k1_q   <= wval;
        D_T1:    t1_q   <= wval;
        D_ERR:   err_q  <= wval;
        D_ANG:   ang_q  <= wval;
        D_SPD:   spd_q  <= wval;
        default: ;
      endcase
    end
    if (state_q == S_DONE && slot_free) begin
      filtered_angle_q <= out_sat(ang_q);
      corrected_rate_q <= out_sat(spd_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_angle_o = filtered_angle_q;
  assign corrected_rate_o = corrected_rate_q;

  // a unit finishing means the sequencer had started it and is waiting
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_done || div_done) |-> busy_q && state_q == S_RUN)
    else $error("arithmetic unit finished without a pending operation");

  a_one_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_done && div_done))
    else $error("both arithmetic units finished together");

  a_no_div_nonpos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && (step_q == ST_K0 || step_q == ST_K1) && !e_pos) |-> !div_ctl.start)
    else $error("divider started on a non-positive innovation variance");

  a_accept_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_RUN && step_q == ST_D0A)
    else $error("accepted sample did not start the update sequence");

endmodule
